>>> rtl/mfr_pkg.sv
// Shared types, constants and codes of the serial request-frame receiver.
package mfr_pkg;

    localparam int PAYLOAD_MAX_DEF = 64;
    localparam int JOB_DEPTH       = 2;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONSOLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REBOOT  = 2'd2;

    localparam logic [BYTE_W-1:0] CHR_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CHR_M       = 8'h4D;
    localparam logic [BYTE_W-1:0] CHR_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CHR_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] REBOOT_RST  = 8'h52;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              armed;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  payload_length;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              last;
    } out_item_t;

    // One unit of work handed from the parser to the result sequencer.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
    } job_t;

endpackage

>>> rtl/mfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mfr_job_fifo.sv
// Short job queue between the frame parser and the result sequencer.
module mfr_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mfr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output mfr_pkg::job_t pop_data,
    output logic          empty
);

    localparam int DEPTH = mfr_pkg::JOB_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    mfr_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mfr_front.sv
// Byte parser: frame header tracking, checksum, payload capture and job creation.
module mfr_front #(
    parameter int PAYLOAD_MAX = mfr_pkg::PAYLOAD_MAX_DEF,
    parameter int AW          = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  mfr_pkg::in_item_t         in_item,
    output logic                      full,
    input  logic                      cfg_wr_en,
    input  logic [mfr_pkg::BYTE_W-1:0] cfg_wr_data,
    input  logic                      job_full,
    output logic                      job_push,
    output mfr_pkg::job_t             job,
    input  logic                      frame_done,
    output logic                      ram_we,
    output logic [AW-1:0]             ram_waddr,
    output logic [mfr_pkg::BYTE_W-1:0] ram_wdata,
    output logic                      frame_busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_M     = 3'd2;
    localparam logic [2:0] ST_ARROW = 3'd3;
    localparam logic [2:0] ST_SIZE  = 3'd4;
    localparam logic [2:0] ST_CMD   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [mfr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [mfr_pkg::LEN_W-1:0]  off_reg, off_next;
    logic [mfr_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [mfr_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic [mfr_pkg::BYTE_W-1:0] reboot_reg, reboot_next;
    logic                       busy_reg, busy_next;
    logic                       collecting;
    logic                       accept;
    logic [mfr_pkg::BYTE_W-1:0] c;

    assign c          = in_item.rx_byte;
    assign collecting = (state_reg == ST_CMD) && (off_reg < len_reg);
    // A new payload must not overwrite the store while a frame is still being read out.
    assign full       = job_full || (collecting && busy_reg);
    assign accept     = push && !full;
    assign frame_busy = busy_reg;
    assign ram_waddr  = off_reg[AW-1:0];
    assign ram_wdata  = c;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        xor_next    = xor_reg;
        cmd_next    = cmd_reg;
        reboot_next = cfg_wr_en ? cfg_wr_data : reboot_reg;
        busy_next   = frame_done ? 1'b0 : busy_reg;
        job_push    = 1'b0;
        job         = '{kind: mfr_pkg::KIND_FRAME, command: '0, length: '0};
        ram_we      = 1'b0;
        if (accept)
        begin
            case (state_reg)
                ST_START:
                begin
                    state_next = (c == mfr_pkg::CHR_M) ? ST_M : ST_IDLE;
                end
                ST_M:
                begin
                    state_next = (c == mfr_pkg::CHR_LT) ? ST_ARROW : ST_IDLE;
                end
                ST_ARROW:
                begin
                    if (c > mfr_pkg::BYTE_W'(PAYLOAD_MAX))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        len_next   = c[mfr_pkg::LEN_W-1:0];
                        off_next   = '0;
                        xor_next   = c;
                        state_next = ST_SIZE;
                    end
                end
                ST_SIZE:
                begin
                    cmd_next   = c;
                    xor_next   = xor_reg ^ c;
                    state_next = ST_CMD;
                end
                ST_CMD:
                begin
                    if (collecting)
                    begin
                        xor_next = xor_reg ^ c;
                        ram_we   = 1'b1;
                        off_next = mfr_pkg::LEN_W'(off_reg + 1'b1);
                    end
                    else
                    begin
                        if (xor_reg == c)
                        begin
                            job_push = 1'b1;
                            job      = '{kind: mfr_pkg::KIND_FRAME, command: cmd_reg,
                                         length: len_reg};
                            if (len_reg != '0)
                            begin
                                busy_next = 1'b1;
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    if (c == mfr_pkg::CHR_DOLLAR)
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (!in_item.armed)
                        begin
                            if (c == mfr_pkg::CHR_HASH)
                            begin
                                job_push = 1'b1;
                                job.kind = mfr_pkg::KIND_CONSOLE;
                            end
                            else if (c == reboot_reg)
                            begin
                                job_push = 1'b1;
                                job.kind = mfr_pkg::KIND_REBOOT;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            off_reg    <= '0;
            xor_reg    <= '0;
            cmd_reg    <= '0;
            reboot_reg <= mfr_pkg::REBOOT_RST;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            off_reg    <= off_next;
            xor_reg    <= xor_next;
            cmd_reg    <= cmd_next;
            reboot_reg <= reboot_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

>>> rtl/mfr_back.sv
// Result sequencer: expands jobs into result transactions and holds the output register.
module mfr_back #(
    parameter int PAYLOAD_MAX = mfr_pkg::PAYLOAD_MAX_DEF,
    parameter int AW          = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_empty,
    input  mfr_pkg::job_t              job,
    output logic                       job_pop,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [mfr_pkg::BYTE_W-1:0] ram_rdata,
    output logic                       frame_done,
    output mfr_pkg::out_item_t         result,
    output logic                       empty,
    input  logic                       pop
);

    localparam logic [1:0] BK_IDLE   = 2'd0;
    localparam logic [1:0] BK_SINGLE = 2'd1;
    localparam logic [1:0] BK_READ   = 2'd2;
    localparam logic [1:0] BK_LOAD   = 2'd3;

    logic [1:0]                state_reg, state_next;
    mfr_pkg::job_t             job_reg, job_next;
    logic [mfr_pkg::LEN_W-1:0] idx_reg, idx_next;
    mfr_pkg::out_item_t        out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;
    logic                      is_last;

    assign out_free  = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign ram_raddr = idx_reg[AW-1:0];
    assign is_last   = (mfr_pkg::LEN_W'(idx_reg + 1'b1) == job_reg.length);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = (pop && out_valid_reg) ? 1'b0 : out_valid_reg;
        job_pop        = 1'b0;
        ram_re         = 1'b0;
        frame_done     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    idx_next = '0;
                    if (job.kind == mfr_pkg::KIND_FRAME && job.length != '0)
                    begin
                        state_next = BK_READ;
                    end
                    else
                    begin
                        state_next = BK_SINGLE;
                    end
                end
            end
            BK_SINGLE:
            begin
                if (out_free)
                begin
                    out_next = '{event_kind: job_reg.kind, command: job_reg.command,
                                 payload_length: job_reg.length, byte_index: '0,
                                 payload_byte: '0, has_byte: 1'b0, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            BK_READ:
            begin
                ram_re     = 1'b1;
                state_next = BK_LOAD;
            end
            default:
            begin
                if (out_free)
                begin
                    out_next = '{event_kind: mfr_pkg::KIND_FRAME, command: job_reg.command,
                                 payload_length: job_reg.length,
                                 byte_index: idx_reg[mfr_pkg::IDX_W-1:0],
                                 payload_byte: ram_rdata, has_byte: 1'b1, last: is_last};
                    out_valid_next = 1'b1;
                    if (is_last)
                    begin
                        frame_done = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = mfr_pkg::LEN_W'(idx_reg + 1'b1);
                        state_next = BK_READ;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

endmodule

>>> rtl/msp_frame_receiver_unit.sv
// Top level of the serial request-frame receiver: parser, job queue, payload RAM, sequencer.
// Each result passes the job queue, the sequencer and the output register. Bytes are taken
// one per cycle; full holds back payload bytes while the previous frame is read out
// (registered RAM read, then output load), and every byte while the job queue is full.
// Reset (rst_n, asynchronous, active low) idles the parser, empties the job queue and
// output register and sets the reboot char to 'R'.
module msp_frame_receiver_unit #(
    parameter int PAYLOAD_MAX = mfr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mfr_pkg::in_item_t          in_item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output mfr_pkg::out_item_t         result,
    input  logic                       cfg_wr_en,
    input  logic [mfr_pkg::BYTE_W-1:0] cfg_wr_data
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // Jobs handed from the parser to the sequencer through the short queue.
    logic                       job_push;
    mfr_pkg::job_t              job_in;
    logic                       job_full;
    logic                       job_pop;
    mfr_pkg::job_t              job_out;
    logic                       job_empty;

    // Payload store: written by the parser, read by the sequencer.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [mfr_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [mfr_pkg::BYTE_W-1:0] ram_rdata;

    // The sequencer pulses frame_done when it has read the last payload byte, which
    // frees the payload store for the next frame's bytes.
    logic                       frame_done;
    logic                       frame_busy;

    mfr_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .AW          (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_item     (in_item),
        .full        (full),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_full    (job_full),
        .job_push    (job_push),
        .job         (job_in),
        .frame_done  (frame_done),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .frame_busy  (frame_busy)
    );

    mfr_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    mfr_ram #(
        .WIDTH (mfr_pkg::BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mfr_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .AW          (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (job_empty),
        .job        (job_out),
        .job_pop    (job_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .frame_done (frame_done),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    // The payload store is never written while a frame is still being read out of it.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && frame_busy))
        else $error("payload written while previous frame is being read out");

    // The parser only creates a job when the queue has room for it.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
        else $error("job pushed into a full queue");

    // The sequencer only takes a job that is really waiting.
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !job_empty)
        else $error("job popped from an empty queue");

    // Finishing a frame readout always leaves a frame marked as in flight beforehand.
    assert property (@(posedge clk) disable iff (!rst_n) frame_done |-> frame_busy)
        else $error("frame readout finished with no frame in flight");

endmodule

>>> tb/tb_msp_frame_receiver_unit.sv
// Self-checking testbench for the serial request-frame receiver with a class-based scoreboard.
`timescale 1ns / 100ps

module tb_msp_frame_receiver_unit;

    // Parser position within a request frame. Only idle and the five header and
    // body positions are reachable; anything else is handled like idle.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_M,
        PH_ARROW,
        PH_LENGTH,
        PH_COMMAND
    } frame_phase_t;

    // Scoreboard: mirrors the frame parser byte by byte, queues the events that the
    // block must produce, and checks every popped result against the oldest one.
    class msp_event_tracker;
        frame_phase_t        phase;
        logic [6:0]          frame_len;
        logic [6:0]          fill_count;
        logic [7:0]          xor_acc;
        logic [7:0]          cmd_byte;
        logic [7:0]          payload_mem [64];
        logic [7:0]          reboot_code;
        mfr_pkg::out_item_t  pending_events [$];
        int                  fault_count;
        int                  results_matched;
        int                  frames_emitted;
        int                  requests_emitted;

        function new();
            phase            = PH_IDLE;
            frame_len        = '0;
            fill_count       = '0;
            xor_acc          = '0;
            cmd_byte         = '0;
            reboot_code      = mfr_pkg::REBOOT_RST;
            fault_count      = 0;
            results_matched  = 0;
            frames_emitted   = 0;
            requests_emitted = 0;
        endfunction

        function void set_reboot_char(logic [7:0] value);
            reboot_code = value;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        // Called once per accepted input transaction.
        function void take_byte(mfr_pkg::in_item_t item);
            logic [7:0]         c;
            mfr_pkg::out_item_t ev;
            int                 i;
            c  = item.rx_byte;
            ev = '0;
            ev.last = 1'b1;
            case (phase)
                PH_DOLLAR: phase = (c == mfr_pkg::CHR_M) ? PH_M : PH_IDLE;
                PH_M:      phase = (c == mfr_pkg::CHR_LT) ? PH_ARROW : PH_IDLE;
                PH_ARROW:
                begin
                    // An oversized length aborts the frame and is not seen as idle data.
                    if (c > 8'(mfr_pkg::PAYLOAD_MAX_DEF))
                    begin
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        frame_len  = c[6:0];
                        fill_count = '0;
                        xor_acc    = c;
                        phase      = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    cmd_byte = c;
                    xor_acc  = xor_acc ^ c;
                    phase    = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    if (fill_count < frame_len)
                    begin
                        xor_acc = xor_acc ^ c;
                        payload_mem[fill_count[5:0]] = c;
                        fill_count = fill_count + 7'd1;
                    end
                    else
                    begin
                        // Checksum byte: a mismatch drops the frame without a trace.
                        if (xor_acc == c)
                        begin
                            frames_emitted++;
                            ev.event_kind = mfr_pkg::KIND_FRAME;
                            ev.command    = cmd_byte;
                            if (frame_len == '0)
                            begin
                                pending_events.push_back(ev);
                            end
                            else
                            begin
                                for (i = 0; i < int'(frame_len); i++)
                                begin
                                    ev.payload_length = frame_len;
                                    ev.byte_index     = 6'(i);
                                    ev.payload_byte   = payload_mem[i];
                                    ev.has_byte       = 1'b1;
                                    ev.last           = (i + 1 == int'(frame_len));
                                    pending_events.push_back(ev);
                                end
                            end
                        end
                        phase = PH_IDLE;
                    end
                end
                default:
                begin
                    if (c == mfr_pkg::CHR_DOLLAR)
                    begin
                        phase = PH_DOLLAR;
                    end
                    else
                    begin
                        phase = PH_IDLE;
                        // The console request wins over a reboot character equal to it.
                        if (!item.armed && c == mfr_pkg::CHR_HASH)
                        begin
                            ev.event_kind = mfr_pkg::KIND_CONSOLE;
                            pending_events.push_back(ev);
                            requests_emitted++;
                        end
                        else if (!item.armed && c == reboot_code)
                        begin
                            ev.event_kind = mfr_pkg::KIND_REBOOT;
                            pending_events.push_back(ev);
                            requests_emitted++;
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                fault_count++;
                if (fault_count <= 200)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, want, got);
            end
        endfunction

        // Called once per accepted result transaction.
        function void match_event(mfr_pkg::out_item_t got);
            mfr_pkg::out_item_t want;
            if (pending_events.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 200)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
            end
            else
            begin
                want = pending_events.pop_front();
                results_matched++;
                compare_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
                compare_field("command", want.command, got.command);
                compare_field("payload_length", 8'(want.payload_length),
                              8'(got.payload_length));
                compare_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
                compare_field("payload_byte", want.payload_byte, got.payload_byte);
                compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
                compare_field("last", 8'(want.last), 8'(got.last));
            end
        endfunction

        function void close_out();
            if (pending_events.size() != 0)
            begin
                fault_count += pending_events.size();
                $display("%0t: %0d results never arrived, oldest expected %h, actual none",
                         $time, pending_events.size(), pending_events[0]);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    mfr_pkg::in_item_t   in_item     = '0;
    logic                full;
    logic                empty;
    logic                pop         = 1'b0;
    mfr_pkg::out_item_t  result;
    logic                cfg_wr_en   = 1'b0;
    logic [7:0]          cfg_wr_data = '0;

    msp_event_tracker tracker = new();

    int          burst_left  = 0;
    int          bytes_sent  = 0;
    int          full_stalls = 0;
    logic [7:0]  reboot_now  = mfr_pkg::REBOOT_RST;
    bit          hold_req    = 1'b0;

    msp_frame_receiver_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_item     (in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses results.
    initial
    begin
        #4_000_000;
        $display("tb_msp_frame_receiver_unit NOT OK");
        $finish;
    end

    // The armed flag is set on about a quarter of the bytes.
    function automatic logic arm_bit();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // Offers one byte and returns at the edge where the block takes it. The sender
    // works in bursts; push only drops when a gap between bursts begins or the sender waits
    // for the block to drain, so it is never lowered and raised in the same time step.
    task automatic send_byte(input logic [7:0] value, input logic arm);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push    <= 1'b1;
        in_item <= '{rx_byte: value, armed: arm};
        @(posedge clk);
        // Outputs are read right after the edge, so they still hold the values that
        // the block saw at that edge.
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        tracker.take_byte(in_item);
        bytes_sent++;
    endtask

    task automatic send_header();
        send_byte(mfr_pkg::CHR_DOLLAR, arm_bit());
        send_byte(mfr_pkg::CHR_M, arm_bit());
        send_byte(mfr_pkg::CHR_LT, arm_bit());
    endtask

    // A complete request frame with random payload; corrupt spoils the checksum.
    task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        send_header();
        sum = 8'(len);
        send_byte(8'(len), arm_bit());
        sum = sum ^ cmd;
        send_byte(cmd, arm_bit());
        repeat (len)
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            send_byte(b, arm_bit());
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum, arm_bit());
    endtask

    // Mostly well-formed frames with random content, plus broken frames and line noise.
    task automatic send_mixed_sequence();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 64) : $urandom_range(0, 8);
            send_frame(len, 8'($urandom), 1'b0);
        end
        else if (pick < 65)
        begin
            send_frame($urandom_range(0, 6), 8'($urandom), 1'b1);
        end
        else if (pick < 73)
        begin
            send_header();
            send_byte(8'($urandom_range(mfr_pkg::PAYLOAD_MAX_DEF + 1, 255)), arm_bit());
        end
        else if (pick < 80)
        begin
            send_byte(mfr_pkg::CHR_DOLLAR, arm_bit());
            if ($urandom_range(0, 1) == 0)
            begin
                do b = 8'($urandom); while (b == mfr_pkg::CHR_M);
            end
            else
            begin
                send_byte(mfr_pkg::CHR_M, arm_bit());
                do b = 8'($urandom); while (b == mfr_pkg::CHR_LT);
            end
            send_byte(b, arm_bit());
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0:       b = mfr_pkg::CHR_HASH;
                    1:       b = reboot_now;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, arm_bit());
            end
        end
    endtask

    // Stops sending and waits until every expected result has been popped, then waits on
    // so that a byte still inside the block cannot be overtaken.
    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reboot_char(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        tracker.set_reboot_char(value);
        reboot_now = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: stretches of random length in which the receiver is always ready,
    // ready half of the time, or mostly stalled. Once the stimulus asks for it, it
    // holds off completely for a long stretch so that the block fills and stalls.
    initial
    begin : result_side
        int stretch_left;
        int mode;
        int hold_left;
        bit hold_taken;
        stretch_left = 0;
        mode         = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                tracker.match_event(result);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 400;
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(1, 40);
                mode         = $urandom_range(0, 2);
            end
            stretch_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] reboot_plan [5];
        int         p;
        int         phase_start;
        reboot_plan[0] = 8'h00;
        reboot_plan[1] = 8'hFF;
        reboot_plan[2] = mfr_pkg::CHR_HASH;
        reboot_plan[3] = mfr_pkg::CHR_DOLLAR;
        reboot_plan[4] = 8'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reboot character still at its reset value.
        send_frame(0, 8'hFF, 1'b0);                     // empty frame gives a single result
        send_frame(1, 8'h00, 1'b0);
        send_header();
        send_byte(8'd65, 1'b0);                         // one above the largest length
        send_header();
        send_byte(mfr_pkg::REBOOT_RST, 1'b0);           // oversized length equal to reboot char
        send_byte(mfr_pkg::CHR_DOLLAR, 1'b0);
        send_byte(mfr_pkg::CHR_HASH, 1'b0);             // bad header byte is not a console request
        send_byte(mfr_pkg::CHR_DOLLAR, 1'b0);
        send_byte(mfr_pkg::CHR_M, 1'b0);
        send_byte(mfr_pkg::REBOOT_RST, 1'b0);           // bad header byte is not a reboot request
        send_byte(mfr_pkg::CHR_HASH, 1'b1);             // armed: ignored
        send_byte(mfr_pkg::CHR_HASH, 1'b0);
        send_byte(mfr_pkg::REBOOT_RST, 1'b1);           // armed: ignored
        send_byte(mfr_pkg::REBOOT_RST, 1'b0);

        // Random part, split into phases with a different reboot character each.
        for (p = 0; p < 5; p++)
        begin
            wait_drained();
            write_reboot_char(reboot_plan[p]);
            phase_start = bytes_sent;
            send_byte(reboot_plan[p], 1'b0);
            send_byte(reboot_plan[p], 1'b1);
            send_byte(mfr_pkg::CHR_HASH, 1'b0);
            if (p == 1)
            begin
                // Short frames pile up behind the stalled result side.
                hold_req = 1'b1;
                repeat (4) send_frame($urandom_range(0, 2), 8'($urandom), 1'b0);
            end
            if (p == 2)
                send_frame(mfr_pkg::PAYLOAD_MAX_DEF, 8'($urandom), 1'b0);
            while (bytes_sent - phase_start < 8)
                send_mixed_sequence();
        end

        wait_drained();
        tracker.close_out();
        $display("Sent %0d bytes under six reboot characters; %0d results checked from",
                 bytes_sent, tracker.results_matched);
        $display("%0d frames and %0d requests; a full block held the sender for %0d cycles.",
                 tracker.frames_emitted, tracker.requests_emitted, full_stalls);
        if (tracker.fault_count == 0)
            $display("tb_msp_frame_receiver_unit OK");
        else
            $display("tb_msp_frame_receiver_unit NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/mfr_pkg.sv
rtl/mfr_ram.sv
rtl/mfr_job_fifo.sv
rtl/mfr_front.sv
rtl/mfr_back.sv
rtl/msp_frame_receiver_unit.sv
tb/tb_msp_frame_receiver_unit.sv
